FILE: rtl/clr_pkg.sv
// Package for the clamped line rasterizer.
// Holds the queue entry type, the command codes and the internal widths.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package clr_pkg;

    localparam int COORD_W     = 10;
    localparam int POS_W       = 12;
    localparam int ACC_W       = 11;
    localparam int CNT_W       = 11;
    localparam int IN_FIELD_W  = 12;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } func_t;

    typedef logic [COORD_W-1:0]      coord_t;
    typedef logic signed [1:0]       step_t;
    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct packed {
        func_t       func;
        logic        x_is_major;
        step_t       step_x;
        step_t       step_y;
        coord_t      x0;
        coord_t      y0;
        coord_t      major_delta;
        coord_t      minor_delta;
        logic [15:0] color;
        logic        xor_write;
    } cmd_t;

endpackage

FILE: rtl/clr_front.sv
// Front end of the clamped line rasterizer: accepts input words, clamps the
// endpoints and classifies the line into major and minor deltas and steps.
// Depends on clr_pkg.
`timescale 1ns / 1ps

module clr_front #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [clr_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            q_full,
    output logic                            push,
    output clr_pkg::cmd_t                   cmd
);
    import clr_pkg::*;

    localparam logic signed [IN_FIELD_W-1:0] X_LIM = IN_FIELD_W'(FRAME_WIDTH - 2);
    localparam logic signed [IN_FIELD_W-1:0] Y_LIM = IN_FIELD_W'(FRAME_HEIGHT - 2);
    localparam coord_t X_MAX = COORD_W'(FRAME_WIDTH - 1);
    localparam coord_t Y_MAX = COORD_W'(FRAME_HEIGHT - 1);

    function automatic coord_t clamp_coord(input logic signed [IN_FIELD_W-1:0] v,
                                           input logic signed [IN_FIELD_W-1:0] lim,
                                           input coord_t hi);
        coord_t r;
        if (v < 12'sd1) begin
            r = '0;
        end else if (v > lim) begin
            r = hi;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic step_t sign_of(input logic signed [COORD_W:0] d);
        step_t r;
        if (d > 0) begin
            r = 2'sb01;
        end else if (d < 0) begin
            r = 2'sb11;
        end else begin
            r = 2'sb00;
        end
        return r;
    endfunction

    coord_t x1, y1, x2, y2;
    logic signed [COORD_W:0] dx, dy;
    coord_t adx, ady;

    always_comb begin
        x1 = clamp_coord(s_tdata[11:0],  X_LIM, X_MAX);
        y1 = clamp_coord(s_tdata[23:12], Y_LIM, Y_MAX);
        x2 = clamp_coord(s_tdata[35:24], X_LIM, X_MAX);
        y2 = clamp_coord(s_tdata[47:36], Y_LIM, Y_MAX);
        dx = $signed({1'b0, x2}) - $signed({1'b0, x1});
        dy = $signed({1'b0, y2}) - $signed({1'b0, y1});
        adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

        cmd.func       = func_t'(s_tuser);
        cmd.x_is_major = (adx >= ady);
        cmd.step_x     = sign_of(dx);
        cmd.step_y     = sign_of(dy);
        cmd.x0         = x1;
        cmd.y0         = y1;
        cmd.major_delta = (adx >= ady) ? adx : ady;
        cmd.minor_delta = (adx >= ady) ? ady : adx;
        cmd.color      = s_tdata[63:48];
        cmd.xor_write  = s_tdata[64];
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

endmodule

FILE: rtl/clr_queue.sv
// Short command queue between the front end and the pixel engine.
// Depends on clr_pkg for the entry type and depth.
`timescale 1ns / 1ps

module clr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  clr_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output clr_pkg::cmd_t  head_cmd
);
    import clr_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/clr_engine.sv
// Pixel engine of the clamped line rasterizer: runs the error-accumulator
// line walk, one pixel per start command or step of an active line, and holds each
// pixel in an output register. Depends on clr_pkg.
`timescale 1ns / 1ps

module clr_engine (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             head_valid,
    input  clr_pkg::cmd_t                    head_cmd,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [clr_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);
    import clr_pkg::*;

    pos_t        cur_x_reg, cur_x_next;
    pos_t        cur_y_reg, cur_y_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] left_reg, left_next;
    coord_t      major_reg, minor_reg;
    step_t       step_x_reg, step_y_reg;
    logic        x_major_reg;
    logic [15:0] color_reg;
    logic        xor_reg;
    logic        active_reg, active_next;

    logic        m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic        m_last_reg;

    logic        is_start, emit, fire, out_ready, hit, last_pix;
    pos_t        base_x, base_y, sx, sy, px, py;
    coord_t      major_u, minor_u;
    logic        xmaj;
    logic [ACC_W-1:0] acc_base, acc_sum;
    logic [15:0] color_u;
    logic        xor_u;

    always_comb begin
        is_start  = (head_cmd.func == FUNC_START);
        emit      = is_start || active_reg;
        out_ready = !m_valid_reg || m_tready;
        pop       = head_valid && (out_ready || !emit);
        fire      = pop && emit;

        base_x   = is_start ? pos_t'({2'b00, head_cmd.x0}) : cur_x_reg;
        base_y   = is_start ? pos_t'({2'b00, head_cmd.y0}) : cur_y_reg;
        acc_base = is_start ? '0 : acc_reg;
        major_u  = is_start ? head_cmd.major_delta : major_reg;
        minor_u  = is_start ? head_cmd.minor_delta : minor_reg;
        xmaj     = is_start ? head_cmd.x_is_major : x_major_reg;
        sx       = pos_t'(is_start ? head_cmd.step_x : step_x_reg);
        sy       = pos_t'(is_start ? head_cmd.step_y : step_y_reg);
        color_u  = is_start ? head_cmd.color : color_reg;
        xor_u    = is_start ? head_cmd.xor_write : xor_reg;

        acc_sum  = acc_base + ACC_W'(minor_u);
        hit      = (acc_sum >= ACC_W'(major_u));
        acc_next = hit ? acc_sum - ACC_W'(major_u) : acc_sum;

        px = base_x + ((hit && !xmaj) ? sx : '0);
        py = base_y + ((hit && xmaj) ? sy : '0);
        cur_x_next = px + (xmaj ? sx : '0);
        cur_y_next = py + (xmaj ? '0 : sy);

        if (is_start) begin
            left_next = CNT_W'(head_cmd.major_delta);
        end else if (left_reg != '0) begin
            left_next = left_reg - 1'b1;
        end else begin
            left_next = '0;
        end
        last_pix    = (left_next == '0);
        active_next = !last_pix;

        m_data_next = {4'b0000, xor_u, color_u, py[9:0], px[8:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            acc_reg     <= '0;
            left_reg    <= '0;
            major_reg   <= '0;
            minor_reg   <= '0;
            step_x_reg  <= '0;
            step_y_reg  <= '0;
            x_major_reg <= 1'b0;
            color_reg   <= '0;
            xor_reg     <= 1'b0;
            active_reg  <= 1'b0;
        end else if (fire) begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            acc_reg     <= acc_next;
            left_reg    <= left_next;
            active_reg  <= active_next;
            major_reg   <= major_u;
            minor_reg   <= minor_u;
            step_x_reg  <= is_start ? head_cmd.step_x : step_x_reg;
            step_y_reg  <= is_start ? head_cmd.step_y : step_y_reg;
            x_major_reg <= xmaj;
            color_reg   <= color_u;
            xor_reg     <= xor_u;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= m_data_next;
            m_last_reg <= last_pix;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/clamped_line_rasterizer.sv
// Clamped line rasterizer: a start word yields the first pixel of a line,
// each step word the next pixel while the line has pixels left (later step
// words are dropped); one word and one pixel per clock unless m_tready stalls.
// A taken word is written into the queue, then the engine registers its pixel
// in the output register that drives m_tvalid; the error update is combinational.
// Reset: synchronous active-low aresetn empties the queue and idles the line.
`timescale 1ns / 1ps

module clamped_line_rasterizer #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // x_start[11:0], y_start[23:12], x_end[35:24], y_end[47:36],
    // pen_color[63:48], xor_write[64], zero fill above.
    input  logic [clr_pkg::IN_TDATA_W-1:0]   s_tdata,
    // func[0].
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_x[8:0], pixel_y[18:9], pixel_color[34:19], pixel_xor[35], zero fill above.
    output logic [clr_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);
    import clr_pkg::*;

    cmd_t front_cmd, head_cmd;
    logic push, q_full, pop, head_valid;

    clr_front #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .FRAME_HEIGHT(FRAME_HEIGHT)
    ) u_front (
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_full  (q_full),
        .push    (push),
        .cmd     (front_cmd)
    );

    clr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_cmd  (head_cmd)
    );

    clr_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
